// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TUN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TUN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// widths, constants and types shared by the triangle normal pipeline
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int NC_W      = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int LO_W      = 32;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int S_W       = SQ_W + 2;
  localparam int CMP_W     = S_W + 64;
  localparam int LEN_EXTRA = 16;
  localparam int RAD_W     = S_W + 2 * LEN_EXTRA;
  localparam int LEN_W     = RAD_W / 2;
  localparam int SQ_REM_W  = LEN_W + 3;
  localparam int NUM_SHIFT = 31 + LEN_EXTRA;
  localparam int Q_W       = 33;
  localparam int DREM_W    = LEN_W + Q_W + 1;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 32;
  localparam int MSQ_W     = 2 * CFG_W;
  localparam int ADDR_W    = 3;

  localparam bit RAW_RIGHT = (2 * COORD_FRAC_BITS) > 30;
  localparam int RAW_K     = RAW_RIGHT ? (2 * COORD_FRAC_BITS - 30) : 1;
  localparam int RAW_L     = RAW_RIGHT ? 0 : (30 - 2 * COORD_FRAC_BITS);

  localparam logic [63:0]      ONE_Q30          = 64'h0000_0000_4000_0000;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 32'd4295;
  localparam logic             REG_MIN_LENGTH   = 1'b0;

  typedef logic [8:0][COORD_W-1:0] vtx_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic                  degen;
  } side_t;

  typedef struct packed {
    logic [2:0][OUT_W-1:0] normal;
    logic                  degen;
  } res_t;

endpackage

// File: rtl/core/tun_if.sv
// ----------------------------------------------------------------------------
// tun_if
// valid/ready channels for triangle items and normal items
// ----------------------------------------------------------------------------
interface tun_in_if import tun_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] a_x, a_y, a_z;
  logic signed [COORD_W-1:0] b_x, b_y, b_z;
  logic signed [COORD_W-1:0] c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tun_out_if import tun_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
  logic                    degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// File: rtl/core/tun_cross.sv
// ----------------------------------------------------------------------------
// tun_cross
// edges, cross product, squared length and degenerate test in eight stages
// ----------------------------------------------------------------------------
module tun_cross import tun_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vtx_t             vtx_i,
  input  logic [CFG_W-1:0] min_length_i,
  output logic             valid_o,
  output logic [S_W-1:0]   s_o,
  output side_t            side_o
);

  logic [7:0] v_q;

  logic signed [2:0][EDGE_W-1:0] ab_q, ac_q;
  logic signed [2:0][PROD_W-1:0] p0_q, p1_q;
  logic signed [2:0][NC_W-1:0]   n_q;
  logic [2:0]                    neg4_q;
  logic [2:0][MAG_W-1:0]         mag4_q;
  logic [2:0][2*HI_W-1:0]        hh_q;
  logic [2:0][HI_W+LO_W-1:0]     hl_q;
  logic [2:0][2*LO_W-1:0]        ll_q;
  side_t                         sd5_q, sd6_q, sd7_q, side_q;
  logic [2:0][SQ_W-1:0]          sq_q;
  logic [S_W-1:0]                s7_q, s_q;
  logic [MSQ_W-1:0]              msq_q;

  logic [CMP_W-1:0] lhs, rhs;
  logic signed [2:0][NC_W-1:0] nabs;
  side_t sd5_d, sd8_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nabs[c] = n_q[c][NC_W-1] ? -n_q[c] : n_q[c];
    end
    sd5_d.neg   = neg4_q;
    sd5_d.mag   = mag4_q;
    sd5_d.degen = 1'b0;
    lhs = {s7_q, 64'b0};
    rhs = CMP_W'(msq_q) << (4 * COORD_FRAC_BITS);
    sd8_d = sd7_q;
    sd8_d.degen = (s7_q == '0) || (lhs < rhs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    msq_q <= MSQ_W'(min_length_i) * MSQ_W'(min_length_i);
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        ab_q[c] <= EDGE_W'($signed(vtx_i[3+c])) - EDGE_W'($signed(vtx_i[c]));
        ac_q[c] <= EDGE_W'($signed(vtx_i[6+c])) - EDGE_W'($signed(vtx_i[c]));
        n_q[c]  <= NC_W'($signed(p0_q[c])) - NC_W'($signed(p1_q[c]));
        neg4_q[c] <= n_q[c][NC_W-1];
        mag4_q[c] <= nabs[c][MAG_W-1:0];
        hh_q[c] <= mag4_q[c][MAG_W-1:LO_W] * mag4_q[c][MAG_W-1:LO_W];
        hl_q[c] <= mag4_q[c][MAG_W-1:LO_W] * mag4_q[c][LO_W-1:0];
        ll_q[c] <= mag4_q[c][LO_W-1:0] * mag4_q[c][LO_W-1:0];
        sq_q[c] <= (SQ_W'(hh_q[c]) << (2 * LO_W)) + (SQ_W'(hl_q[c]) << (LO_W + 1))
                   + SQ_W'(ll_q[c]);
      end
      p0_q[0] <= $signed(ab_q[1]) * $signed(ac_q[2]);
      p1_q[0] <= $signed(ab_q[2]) * $signed(ac_q[1]);
      p0_q[1] <= $signed(ab_q[2]) * $signed(ac_q[0]);
      p1_q[1] <= $signed(ab_q[0]) * $signed(ac_q[2]);
      p0_q[2] <= $signed(ab_q[0]) * $signed(ac_q[1]);
      p1_q[2] <= $signed(ab_q[1]) * $signed(ac_q[0]);
      sd5_q  <= sd5_d;
      sd6_q  <= sd5_q;
      sd7_q  <= sd6_q;
      s7_q   <= S_W'(sq_q[0]) + S_W'(sq_q[1]) + S_W'(sq_q[2]);
      side_q <= sd8_d;
      s_q    <= s7_q;
    end
  end

  assign valid_o = v_q[7];
  assign s_o     = s_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/tun_sqrt.sv
// ----------------------------------------------------------------------------
// tun_sqrt
// restoring square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module tun_sqrt import tun_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [S_W-1:0]   s_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [LEN_W-1:0] len_o,
  output side_t            side_o
);

  logic                v_q   [LEN_W];
  logic [S_W-1:0]      s_q   [LEN_W-1];
  side_t               sd_q  [LEN_W];
  logic [LEN_W-1:0]    res_q [LEN_W];
  logic [SQ_REM_W-1:0] rem_q [LEN_W];

  for (genvar k = 0; k < LEN_W; k++) begin : g_st
    localparam int P = LEN_W - 1 - k;
    logic                v_p;
    logic [S_W-1:0]      s_p;
    side_t               sd_p;
    logic [LEN_W-1:0]    res_p;
    logic [SQ_REM_W-1:0] rem_p, rem_sh, trial;
    logic [RAD_W-1:0]    rad;
    logic                ge;

    if (k == 0) begin : g_first
      assign v_p   = valid_i;
      assign s_p   = s_i;
      assign sd_p  = side_i;
      assign res_p = '0;
      assign rem_p = '0;
    end else begin : g_next
      assign v_p   = v_q[k-1];
      assign s_p   = s_q[k-1];
      assign sd_p  = sd_q[k-1];
      assign res_p = res_q[k-1];
      assign rem_p = rem_q[k-1];
    end

    assign rad    = {s_p, {(2 * LEN_EXTRA){1'b0}}};
    assign rem_sh = {rem_p[SQ_REM_W-3:0], rad[2*P+1], rad[2*P]};
    assign trial  = SQ_REM_W'({res_p, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[k]  <= sd_p;
        res_q[k] <= {res_p[LEN_W-2:0], ge};
        rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
      end
    end

    if (k < LEN_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          s_q[k] <= s_p;
        end
      end
    end
  end

  assign valid_o = v_q[LEN_W-1];
  assign len_o   = res_q[LEN_W-1];
  assign side_o  = sd_q[LEN_W-1];

endmodule

// File: rtl/core/tun_div.sv
// ----------------------------------------------------------------------------
// tun_div
// three-lane restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module tun_div import tun_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [LEN_W-1:0]    len_i,
  input  side_t               side_i,
  output logic                valid_o,
  output logic [2:0][Q_W-1:0] q_o,
  output side_t               side_o
);

  logic                   v_q   [Q_W];
  logic [LEN_W-1:0]       len_q [Q_W-1];
  side_t                  sd_q  [Q_W];
  logic [2:0][Q_W-1:0]    q_q   [Q_W];
  logic [2:0][DREM_W-1:0] rem_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int J = Q_W - 1 - k;
    logic                   v_p;
    logic [LEN_W-1:0]       len_p;
    side_t                  sd_p;
    logic [2:0][Q_W-1:0]    q_p;
    logic [2:0][DREM_W-1:0] rem_p, rem_n;
    logic [2:0]             ge;
    logic [DREM_W-1:0]      dsh;

    if (k == 0) begin : g_first
      assign v_p   = valid_i;
      assign len_p = len_i;
      assign sd_p  = side_i;
      assign q_p   = '0;
      for (genvar c = 0; c < 3; c++) begin : g_ln
        assign rem_p[c] = DREM_W'(side_i.mag[c]) << NUM_SHIFT;
      end
    end else begin : g_next
      assign v_p   = v_q[k-1];
      assign len_p = len_q[k-1];
      assign sd_p  = sd_q[k-1];
      assign q_p   = q_q[k-1];
      assign rem_p = rem_q[k-1];
    end

    assign dsh = DREM_W'(len_p) << J;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        ge[c]    = rem_p[c] >= dsh;
        rem_n[c] = ge[c] ? (rem_p[c] - dsh) : rem_p[c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[k]  <= sd_p;
        rem_q[k] <= rem_n;
        for (int c = 0; c < 3; c++) begin
          q_q[k][c] <= {q_p[c][Q_W-2:0], ge[c]};
        end
      end
    end

    if (k < Q_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          len_q[k] <= len_p;
        end
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign q_o     = q_q[Q_W-1];
  assign side_o  = sd_q[Q_W-1];

endmodule

// File: rtl/core/tun_out.sv
// ----------------------------------------------------------------------------
// tun_out
// rounding, saturation, raw-product path and sign for the normal
// ----------------------------------------------------------------------------
module tun_out import tun_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][Q_W-1:0] q_i,
  input  side_t               side_i,
  output logic                valid_o,
  output res_t                res_o
);

  logic valid_q;
  res_t res_q, res_d;

  always_comb begin
    logic [Q_W:0]  qr;
    logic [63:0]   raw, rn, r;
    res_d.degen = side_i.degen;
    for (int c = 0; c < 3; c++) begin
      qr  = {1'b0, q_i[c]} + (Q_W + 1)'(1);
      rn  = 64'(qr[Q_W:1]);
      raw = side_i.mag[c][63:0];
      if (RAW_RIGHT) begin
        raw = (raw >> RAW_K) + ((raw >> (RAW_K - 1)) & 64'd1);
      end else begin
        raw = raw << RAW_L;
      end
      r = side_i.degen ? raw : rn;
      if (r > ONE_Q30) begin
        r = ONE_Q30;
      end
      res_d.normal[c] = side_i.neg[c] ? (OUT_W'(0) - r[OUT_W-1:0]) : r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/core/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit normal of a triangle from its three vertices
// ----------------------------------------------------------------------------
// in_i carries one triangle per item (vertices A, B, C, signed Q16.16); out_o
// carries one item per triangle: the normal in signed Q2.30 and a degenerate
// flag. A triangle whose cross product length is below min_length gives the
// raw cross product in Q2.30 with degenerate set.
// min_length sits at byte address 0 of the APB port; write it while idle.
// Throughput is one item per cycle unless out_o stalls. From acceptance to
// out_o.valid an item passes 126 register stages, the first loaded when it is
// accepted: 8 of edge, cross product and squared length, 83 of square root
// (one length bit per stage), 33 of division (one quotient bit per stage,
// three lanes), one of rounding and one output register.
// Reset empties the pipeline and loads min_length with 4295 (about 1e-6).
// When out_o stalls, one more item is caught by a skid register; in_i.ready
// then drops and the whole pipeline holds until the skid item is taken.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tun_in_if.sink            in_i,
  tun_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  `include "assert_macros.svh"

  logic [CFG_W-1:0] min_length_q;
  logic             en;
  vtx_t             vtx;

  logic                cr_valid, sq_valid, dv_valid, fin_valid;
  logic [S_W-1:0]      cr_s;
  side_t               cr_side, sq_side, dv_side;
  logic [LEN_W-1:0]    sq_len;
  logic [2:0][Q_W-1:0] dv_q;
  res_t                fin_res;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_MIN_LENGTH) ? min_length_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= MIN_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_MIN_LENGTH)) begin
      min_length_q <= pwdata;
    end
  end

  assign en = !skid_valid_q;
  assign in_i.ready = en;
  assign vtx = {in_i.c_z, in_i.c_y, in_i.c_x, in_i.b_z, in_i.b_y, in_i.b_x,
                in_i.a_z, in_i.a_y, in_i.a_x};

  tun_cross u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .vtx_i(vtx),
    .min_length_i(min_length_q), .valid_o(cr_valid), .s_o(cr_s), .side_o(cr_side)
  );

  tun_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cr_valid), .s_i(cr_s), .side_i(cr_side),
    .valid_o(sq_valid), .len_o(sq_len), .side_o(sq_side)
  );

  tun_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid), .len_i(sq_len), .side_i(sq_side),
    .valid_o(dv_valid), .q_o(dv_q), .side_o(dv_side)
  );

  tun_out u_out (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_valid), .q_i(dv_q), .side_i(dv_side),
    .valid_o(fin_valid), .res_o(fin_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_o.ready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= fin_valid;
    end else if (fin_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_o.ready) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_o.ready) begin
      out_q <= fin_res;
    end else begin
      skid_q <= fin_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.normal_x   = out_q.normal[0];
  assign out_o.normal_y   = out_q.normal[1];
  assign out_o.normal_z   = out_q.normal[2];
  assign out_o.degenerate = out_q.degen;

  `TUN_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
  `TUN_ASSERT_NXT(a_skid_fill, out_valid_q && !out_o.ready && !skid_valid_q && fin_valid, skid_valid_q)
  `TUN_ASSERT_IMP(a_nx_range, out_valid_q, out_o.normal_x >= -32'sd1073741824 && out_o.normal_x <= 32'sd1073741824)
  `TUN_ASSERT_IMP(a_ny_range, out_valid_q, out_o.normal_y >= -32'sd1073741824 && out_o.normal_y <= 32'sd1073741824)
  `TUN_ASSERT_IMP(a_nz_range, out_valid_q, out_o.normal_z >= -32'sd1073741824 && out_o.normal_z <= 32'sd1073741824)

endmodule
